// ===== src/clh_pkg.sv =====
`timescale 1ns / 1ps
package clh_pkg;
   localparam int MAX_BINS    = 1024;
   localparam int COUNT_WIDTH = 32;
   localparam int VAL_W       = 64;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int BINS_W      = 11;
   localparam int SEL_W       = 10;
   localparam int CNT_OUT_W   = 32;
   localparam int QBITS       = 18;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RANGE_LOW  = 2'd0,
      REG_RANGE_HIGH = 2'd1,
      REG_BINS       = 2'd2,
      REG_SPARE      = 2'd3
   } reg_idx_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_WRITE,
      ST_OUT
   } state_type;
endpackage

// ===== src/clh_if.sv =====
`timescale 1ns / 1ps
interface clh_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                command;
   logic signed [63:0]        sample_value;
   logic                      sample_is_number;
   logic [9:0]                bin_select;
   modport source (output valid, command, sample_value, sample_is_number, bin_select,
                   input ready);
   modport sink (input valid, command, sample_value, sample_is_number, bin_select,
                 output ready);
endinterface

interface clh_rsp_if;
   logic        valid;
   logic        ready;
   logic [9:0]  bin_index;
   logic [31:0] bin_count;
   logic [31:0] largest_count;
   logic        sample_skipped;
   modport source (output valid, bin_index, bin_count, largest_count, sample_skipped,
                   input ready);
   modport sink (input valid, bin_index, bin_count, largest_count, sample_skipped,
                 output ready);
endinterface

// ===== src/clamped_linear_histogram_top.sv =====
`timescale 1ns / 1ps
// Channel  | Dir | Words
// req_     | in  | command, sample_value, sample_is_number, bin_select
// rsp_     | out | bin_index, bin_count, largest_count, sample_skipped
// csr_     | in  | write enable, index, data
// An add that divides goes from idle through 18 restoring quotient steps, one multiply
// each, then RAM read, write and output. An add clamped at either end skips the steps;
// a skipped add or a read goes to read then output, command 3 straight to output, and
// clear sweeps all MAX_BINS bins first; after reset such a sweep holds off the input.
// A result holds in the output register until taken; the next word waits.
module clamped_linear_histogram_top #(
   parameter int MAX_BINS    = clh_pkg::MAX_BINS,
   parameter int COUNT_WIDTH = clh_pkg::COUNT_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [clh_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [clh_pkg::CSR_DATA_W-1:0]  csr_write_data,
   clh_req_if.sink                         req,
   clh_rsp_if.source                       rsp
);
   localparam int AW = $clog2(MAX_BINS);
   localparam int NW = $clog2(MAX_BINS + 1);
   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
   localparam int QB = clh_pkg::QBITS;
   localparam int PW = 64 + NW + 1;

   logic [63:0] low_ff, high_ff;
   logic [clh_pkg::BINS_W-1:0] bins_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         high_ff <= 64'd16711680;
         bins_ff <= clh_pkg::BINS_W'(1024);
      end else if (csr_write_enable) begin
         unique case (clh_pkg::reg_idx_type'(csr_index))
            clh_pkg::REG_RANGE_LOW:  low_ff  <= csr_write_data;
            clh_pkg::REG_RANGE_HIGH: high_ff <= csr_write_data;
            clh_pkg::REG_BINS:       bins_ff <= csr_write_data[clh_pkg::BINS_W-1:0];
            default: ;
         endcase
      end
   end

   logic [NW-1:0] nbins;
   always_comb begin
      if (bins_ff == '0) nbins = NW'(1);
      else if (32'(bins_ff) > 32'(MAX_BINS)) nbins = NW'(MAX_BINS);
      else nbins = NW'(bins_ff);
   end

   clh_pkg::state_type st_ff, st_in;
   clh_pkg::cmd_type cmd_ff;
   logic [63:0] span_ff;
   logic [PW-1:0] num_ff;
   logic [QB-1:0] q_ff;
   logic [4:0] step_ff;
   logic [AW:0] sweep_ff;
   logic [AW-1:0] idx_ff;
   logic skip_ff;
   logic [COUNT_WIDTH-1:0] largest_ff;
   logic [COUNT_WIDTH-1:0] cnt_ff;
   logic rv_ff;
   logic [9:0] o_idx_ff;
   logic [31:0] o_cnt_ff;
   logic o_skip_ff;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [COUNT_WIDTH-1:0] wr_data, rd_data;

   clh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(MAX_BINS)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data);

   // trial product of span and candidate quotient, one bit per cycle
   logic [QB-1:0] qt;
   logic [63+QB:0] prod;
   assign qt   = q_ff | (QB'(1) << (5'(QB - 1) - step_ff));
   assign prod = {{QB{1'b0}}, span_ff} * {{64{1'b0}}, qt};

   logic [63:0] s_f, lo_f, hi_f;
   assign s_f  = req.sample_value ^ 64'h8000000000000000;
   assign lo_f = low_ff ^ 64'h8000000000000000;
   assign hi_f = high_ff ^ 64'h8000000000000000;

   logic [63:0] diff;
   assign diff = req.sample_value - low_ff;

   logic accept;
   assign req.ready = (st_ff == clh_pkg::ST_IDLE) && !rv_ff;
   assign accept = req.valid && req.ready;

   logic [COUNT_WIDTH-1:0] inc;
   assign inc = (rd_data == CMAX) ? rd_data : rd_data + COUNT_WIDTH'(1);

   logic [QB-1:0] qclamp;
   assign qclamp = (32'(q_ff) > 32'(nbins) - 32'd1) ? QB'(nbins - NW'(1)) : q_ff;

   always_comb begin
      st_in   = st_ff;
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = inc;
      rd_addr = accept ? AW'(req.bin_select) : idx_ff;
      unique case (st_ff)
         clh_pkg::ST_SWEEP: begin
            wr_en   = 1'b1;
            wr_addr = sweep_ff[AW-1:0];
            wr_data = '0;
            if (sweep_ff == (AW+1)'(MAX_BINS - 1)) st_in = clh_pkg::ST_OUT;
         end
         clh_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (clh_pkg::cmd_type'(req.command))
                  clh_pkg::CMD_CLEAR: st_in = clh_pkg::ST_SWEEP;
                  clh_pkg::CMD_READ:  st_in = clh_pkg::ST_READ;
                  clh_pkg::CMD_ADD:
                     if (!req.sample_is_number || hi_f <= lo_f || s_f <= lo_f ||
                         s_f >= hi_f) st_in = clh_pkg::ST_READ;
                     else st_in = clh_pkg::ST_DIV;
                  default: st_in = clh_pkg::ST_OUT;
               endcase
            end
         end
         clh_pkg::ST_DIV: if (step_ff == 5'(QB - 1)) st_in = clh_pkg::ST_READ;
         clh_pkg::ST_READ: begin
            // read the bin the quotient picked
            if (cmd_ff == clh_pkg::CMD_ADD && !skip_ff && step_ff != '0)
               rd_addr = AW'(qclamp);
            st_in = (cmd_ff == clh_pkg::CMD_ADD && !skip_ff) ? clh_pkg::ST_WRITE
                                                            : clh_pkg::ST_OUT;
         end
         clh_pkg::ST_WRITE: begin
            wr_en = 1'b1;
            st_in = clh_pkg::ST_OUT;
         end
         clh_pkg::ST_OUT: st_in = clh_pkg::ST_IDLE;
         default: st_in = clh_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= clh_pkg::ST_SWEEP;
         sweep_ff   <= '0;
         largest_ff <= '0;
         rv_ff      <= 1'b0;
         cmd_ff     <= clh_pkg::CMD_NONE;
      end else begin
         st_ff <= st_in;
         if (rsp.valid && rsp.ready) rv_ff <= 1'b0;
         unique case (st_ff)
            clh_pkg::ST_SWEEP: sweep_ff <= sweep_ff + (AW+1)'(1);
            clh_pkg::ST_IDLE: if (accept) begin
               cmd_ff  <= clh_pkg::cmd_type'(req.command);
               skip_ff <= !req.sample_is_number;
               span_ff <= high_ff - low_ff;
               q_ff    <= '0;
               step_ff <= '0;
               sweep_ff <= '0;
               if (req.command == clh_pkg::CMD_CLEAR) largest_ff <= '0;
               if (req.command == clh_pkg::CMD_READ) idx_ff <= AW'(req.bin_select);
               else if (hi_f <= lo_f || s_f <= lo_f) idx_ff <= '0;
               else idx_ff <= AW'(nbins - NW'(1));
            end
            clh_pkg::ST_DIV: begin
               if (prod <= (64+QB)'(num_ff)) q_ff <= qt;
               step_ff <= step_ff + 5'd1;
            end
            clh_pkg::ST_READ: if (cmd_ff == clh_pkg::CMD_ADD && !skip_ff && step_ff != '0)
               idx_ff <= AW'(qclamp);
            clh_pkg::ST_WRITE: begin
               cnt_ff <= inc;
               if (inc > largest_ff) largest_ff <= inc;
            end
            clh_pkg::ST_OUT: begin
               // reset sweep ends here with no word to show
               rv_ff     <= !(cmd_ff == clh_pkg::CMD_NONE && sweep_ff != '0);
               o_skip_ff <= (cmd_ff == clh_pkg::CMD_ADD) && skip_ff;
               if (cmd_ff == clh_pkg::CMD_READ) begin
                  o_idx_ff <= 10'(idx_ff);
                  o_cnt_ff <= 32'(rd_data);
               end else if (cmd_ff == clh_pkg::CMD_ADD && !skip_ff) begin
                  o_idx_ff <= 10'(idx_ff);
                  o_cnt_ff <= 32'(cnt_ff);
               end else begin
                  o_idx_ff <= '0;
                  o_cnt_ff <= '0;
               end
               cmd_ff <= clh_pkg::CMD_NONE;
               sweep_ff <= '0;
            end
            default: ;
         endcase
         if (st_ff == clh_pkg::ST_IDLE && accept)
            num_ff <= PW'(diff) * PW'(nbins);
      end
   end

   assign rsp.valid          = rv_ff;
   assign rsp.bin_index      = o_idx_ff;
   assign rsp.bin_count      = o_cnt_ff;
   assign rsp.largest_count  = 32'(largest_ff);
   assign rsp.sample_skipped = o_skip_ff;
endmodule

// ===== src/clh_ram.sv =====
`timescale 1ns / 1ps
module clh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   typedef struct packed {
      logic [9:0]  bin_index;
      logic [31:0] bin_count;
      logic [31:0] largest_count;
      logic        sample_skipped;
   } hist_result_type;

   localparam longint unsigned COUNT_SAT = 64'hFFFF_FFFF;
   localparam int LIMIT_CYCLES = 600000;
   localparam int HOLD_CYCLES = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [clh_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [clh_pkg::CSR_DATA_W-1:0] csr_write_data = '0;

   clh_req_if req ();
   clh_rsp_if rsp ();

   clamped_linear_histogram_top uut (
      .clock(clock), .reset(reset), .csr_write_enable(csr_write_enable),
      .csr_index(csr_index), .csr_write_data(csr_write_data), .req(req), .rsp(rsp)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic signed [63:0] pred_low = 64'sd0;
   logic signed [63:0] pred_high = 64'sd16711680;
   logic [10:0] pred_bins = 11'd1024;
   longint unsigned pred_counts [clh_pkg::MAX_BINS];
   longint unsigned pred_largest = 0;
   hist_result_type expected_results [$];

   int error_count = 0;
   int cycle_count = 0;
   bit src_idle_on = 1'b1;
   bit sink_idle_on = 1'b1;
   bit hold_go = 1'b0;
   bit sink_hold = 1'b0;
   int hold_count = 0;

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("Mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
               cycle_count);
      error_count++;
   endtask

   function automatic int bins_effective();
      if (pred_bins == 0) return 1;
      if (pred_bins > clh_pkg::MAX_BINS) return clh_pkg::MAX_BINS;
      return int'(pred_bins);
   endfunction

   function automatic int bin_of_sample(input logic signed [63:0] sample, input int nbins);
      logic [63:0] diff, span;
      logic [127:0] num, quotient;
      if (pred_high <= pred_low || sample <= pred_low) return 0;
      if (sample >= pred_high) return nbins - 1;
      diff = sample - pred_low;
      span = pred_high - pred_low;
      num = {64'd0, diff} * 128'(nbins);
      quotient = num / {64'd0, span};
      if (quotient > 128'(nbins - 1)) return nbins - 1;
      return int'(quotient);
   endfunction

   function automatic hist_result_type predict_word(input clh_pkg::cmd_type cmd,
         input logic signed [63:0] sample, input logic is_num, input logic [9:0] sel);
      hist_result_type r;
      int b;
      r = '0;
      case (cmd)
         clh_pkg::CMD_CLEAR: begin
            foreach (pred_counts[i]) pred_counts[i] = 0;
            pred_largest = 0;
         end
         clh_pkg::CMD_ADD: begin
            if (!is_num) begin
               r.sample_skipped = 1'b1;
            end else begin
               b = bin_of_sample(sample, bins_effective());
               if (pred_counts[b] < COUNT_SAT) pred_counts[b]++;
               if (pred_counts[b] > pred_largest) pred_largest = pred_counts[b];
               r.bin_index = b[9:0];
               r.bin_count = pred_counts[b][31:0];
            end
         end
         clh_pkg::CMD_READ: begin
            r.bin_index = sel;
            r.bin_count = pred_counts[sel][31:0];
         end
         default: ;
      endcase
      r.largest_count = pred_largest[31:0];
      return r;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Timeout at cycle %0d", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // hold the result side off for a long stretch once asked
   always @(posedge clock) begin
      if (hold_go && hold_count < HOLD_CYCLES) begin
         sink_hold <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         sink_hold <= 1'b0;
      end
   end

   // sink: random stalls, plus the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (sink_hold) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= !(sink_idle_on && $urandom_range(99) < 24);
      end
   end

   always @(posedge clock) begin
      hist_result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected word", rsp.bin_index, 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp.bin_index !== want.bin_index)
               report_mismatch("bin_index", rsp.bin_index, want.bin_index);
            if (rsp.bin_count !== want.bin_count)
               report_mismatch("bin_count", rsp.bin_count, want.bin_count);
            if (rsp.largest_count !== want.largest_count)
               report_mismatch("largest_count", rsp.largest_count, want.largest_count);
            if (rsp.sample_skipped !== want.sample_skipped)
               report_mismatch("sample_skipped", rsp.sample_skipped, want.sample_skipped);
         end
      end
   end

   // offer one word, idle at random first, hold until accepted
   task automatic send_word(input clh_pkg::cmd_type cmd, input logic signed [63:0] sample,
                            input logic is_num, input logic [9:0] sel);
      while (src_idle_on && $urandom_range(99) < 24) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.command <= cmd;
      req.sample_value <= sample;
      req.sample_is_number <= is_num;
      req.bin_select <= sel;
      do @(posedge clock); while (!req.ready);
      expected_results.push_back(predict_word(cmd, sample, is_num, sel));
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (clh_pkg::MAX_BINS + 40) @(posedge clock);
   endtask

   task automatic write_reg(input clh_pkg::reg_idx_type idx, input logic [63:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         clh_pkg::REG_RANGE_LOW: pred_low = value;
         clh_pkg::REG_RANGE_HIGH: pred_high = value;
         clh_pkg::REG_BINS: pred_bins = value[10:0];
         default: ;
      endcase
   endtask

   function automatic logic [63:0] random_word64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic signed [63:0] sample_near_range();
      logic signed [63:0] span;
      span = pred_high - pred_low;
      case ($urandom_range(9))
         0: return pred_low;
         1: return pred_high;
         2: return random_word64();
         3: return pred_low - 64'($urandom_range(100));
         default: return pred_low + 64'({$urandom, $urandom} % (span > 0 ? span : 64'd1));
      endcase
   endfunction

   task automatic test_directed_default();
      send_word(clh_pkg::CMD_READ, 0, 1'b0, 10'd0);
      send_word(clh_pkg::CMD_ADD, 64'sh8000_0000_0000_0000, 1'b1, 0);
      send_word(clh_pkg::CMD_ADD, 64'sh7FFF_FFFF_FFFF_FFFF, 1'b1, 0);
      send_word(clh_pkg::CMD_ADD, 64'sd0, 1'b1, 0);
      send_word(clh_pkg::CMD_ADD, 64'sd16711679, 1'b1, 0);
      send_word(clh_pkg::CMD_ADD, 64'sd16711680, 1'b1, 0);
      send_word(clh_pkg::CMD_ADD, 64'sd8355840, 1'b1, 0);
      send_word(clh_pkg::CMD_ADD, 64'sd100, 1'b0, 0);
      send_word(clh_pkg::CMD_ADD, 64'sd100, 1'b1, 0);
      send_word(clh_pkg::CMD_READ, 0, 1'b1, 10'd1023);
      send_word(clh_pkg::CMD_READ, 0, 1'b0, 10'd0);
      send_word(clh_pkg::CMD_READ, 0, 1'b0, 10'd512);
      send_word(clh_pkg::CMD_NONE, 64'sd5, 1'b1, 10'd3);
      send_word(clh_pkg::CMD_CLEAR, 0, 1'b0, 0);
      send_word(clh_pkg::CMD_READ, 0, 1'b0, 10'd1023);
      drain();
   endtask

   task automatic test_range_extremes();
      // empty range: everything lands in bin 0
      write_reg(clh_pkg::REG_RANGE_LOW, 64'd1000);
      write_reg(clh_pkg::REG_RANGE_HIGH, 64'd1000);
      write_reg(clh_pkg::REG_BINS, 11'd0);
      send_word(clh_pkg::CMD_ADD, 64'sd5000, 1'b1, 0);
      send_word(clh_pkg::CMD_ADD, -64'sd5000, 1'b1, 0);
      drain();
      write_reg(clh_pkg::REG_RANGE_LOW, 64'h8000_0000_0000_0000);
      write_reg(clh_pkg::REG_RANGE_HIGH, 64'h7FFF_FFFF_FFFF_FFFF);
      write_reg(clh_pkg::REG_BINS, 11'd2047);
      send_word(clh_pkg::CMD_ADD, 64'sd0, 1'b1, 0);
      send_word(clh_pkg::CMD_ADD, 64'sh7FFF_FFFF_FFFF_FFFE, 1'b1, 0);
      send_word(clh_pkg::CMD_ADD, 64'sh8000_0000_0000_0001, 1'b1, 0);
      drain();
      write_reg(clh_pkg::REG_BINS, 11'd1);
      send_word(clh_pkg::CMD_ADD, 64'sd12345, 1'b1, 0);
      drain();
   endtask

   task automatic random_phase(input int n);
      clh_pkg::cmd_type cmd;
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 80) cmd = clh_pkg::CMD_ADD;
         else if (k < 93) cmd = clh_pkg::CMD_READ;
         else if (k < 97) cmd = clh_pkg::CMD_NONE;
         else cmd = clh_pkg::CMD_CLEAR;
         send_word(cmd, sample_near_range(), $urandom_range(9) != 0,
                   10'($urandom_range(1023)));
      end
      drain();
   endtask

   task automatic test_random_settings();
      write_reg(clh_pkg::REG_RANGE_LOW, -64'sd65536);
      write_reg(clh_pkg::REG_RANGE_HIGH, 64'sd655360);
      write_reg(clh_pkg::REG_BINS, 11'd7);
      random_phase(100);
      write_reg(clh_pkg::REG_RANGE_LOW, random_word64());
      write_reg(clh_pkg::REG_RANGE_HIGH, random_word64());
      write_reg(clh_pkg::REG_BINS, 11'($urandom_range(1024)));
      random_phase(80);
      src_idle_on = 1'b0;
      sink_idle_on = 1'b0;
      write_reg(clh_pkg::REG_RANGE_LOW, 64'sd0);
      write_reg(clh_pkg::REG_RANGE_HIGH, 64'sd16711680);
      write_reg(clh_pkg::REG_BINS, 11'd1024);
      random_phase(80);
      src_idle_on = 1'b1;
      sink_idle_on = 1'b1;
      write_reg(clh_pkg::REG_BINS, 11'd3);
      random_phase(100);
   endtask

   task automatic test_backpressure();
      hold_go = 1'b1;
      random_phase(30);
   endtask

   initial begin
      req.valid = 1'b0;
      req.command = clh_pkg::CMD_CLEAR;
      req.sample_value = '0;
      req.sample_is_number = 1'b0;
      req.bin_select = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_default();
      test_range_extremes();
      test_random_settings();
      test_backpressure();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
